[hdl/ssfla_pkg.sv]
// Shared types, constants and control codes for the size sorted free list allocator.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssfla_pkg;

    // Table sizes and address width.
    localparam int BLOCK_SLOTS = 64;
    localparam int FREE_SLOTS  = 64;
    localparam int ADDR_BITS   = 28;

    localparam int MAX_SLOTS = (BLOCK_SLOTS > FREE_SLOTS) ? BLOCK_SLOTS : FREE_SLOTS;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int BLK_AW    = $clog2(BLOCK_SLOTS);
    localparam int FREE_AW   = $clog2(FREE_SLOTS);

    // Heap limits and register reset values.
    localparam logic [ADDR_BITS-1:0] MEM_LOW    = ADDR_BITS'(28'h0600000);
    localparam logic [ADDR_BITS-1:0] MEM_HIGH   = ADDR_BITS'(28'hFFFFFFF);
    localparam logic [ADDR_BITS-1:0] SIZE_LIMIT = MEM_HIGH - MEM_LOW;
    localparam logic [ADDR_BITS-1:0] BASE_RESET = ADDR_BITS'(28'd7340040);
    localparam logic [ADDR_BITS-1:0] END_RESET  = ADDR_BITS'(28'hFFFFFFF);

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEAP_BASE = 1'b0,
        REG_HEAP_END  = 1'b1
    } cfg_reg_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIZE  = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_PTR   = 3'd4
    } status_t;

    // Request and result words.
    typedef struct packed {
        logic                 operation;
        logic [ADDR_BITS-1:0] request_size;
        logic [ADDR_BITS-1:0] block_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] granted_address;
        logic [2:0]           status;
    } rsp_t;

    // Table entry layouts.
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] size;
        logic                 in_use;
    } blk_entry_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] size;
        logic [ADDR_BITS-1:0] addr;
    } free_entry_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FS_RD,
        S_FS_CMP,
        S_RM_RD,
        S_RM_WR,
        S_FC_RD,
        S_FC_CMP,
        S_ALLOC_NEW,
        S_BS_RD,
        S_BS_CMP,
        S_IP_RD,
        S_IP_CMP,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } ctrl_state_t;

    // Command field codes.
    typedef enum logic [2:0] {
        IDX_HOLD, IDX_INC, IDX_DEC, IDX_CLR, IDX_FCNT
    } idx_op_t;

    typedef enum logic [1:0] {
        FRD_IDX, FRD_NEXT, FRD_PREV
    } frd_sel_t;

    typedef enum logic [1:0] {
        FWR_NONE, FWR_SHIFT, FWR_INSERT
    } fwr_op_t;

    typedef enum logic [1:0] {
        BWR_NONE, BWR_NEW, BWR_SET_USE, BWR_CLR_USE
    } bwr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD, CNT_INC, CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        RA_ZERO, RA_FOUND, RA_BUMP
    } res_addr_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic      latch;
        idx_op_t   idx_op;
        logic      pos_load;
        logic      free_rd;
        frd_sel_t  free_rd_sel;
        fwr_op_t   free_wr;
        logic      blk_rd;
        bwr_op_t   blk_wr;
        logic      a_from_free;
        logic      hit_load;
        cnt_op_t   fcnt_op;
        logic      res_set;
        status_t   res_status;
        res_addr_t res_addr;
        logic      out_load;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_free;
        logic bad_size;
        logic idx_ge_fcnt;
        logic idx_p1_ge_fcnt;
        logic idx_ge_ccnt;
        logic idx_le_pos;
        logic f_ge_sz;
        logic b_match;
        logic b_in_use;
        logic fcnt_full;
        logic ccnt_full;
        logic exhausted;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[hdl/ssfla_ram.sv]
// Generic simple dual port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ssfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/ssfla_ctrl.sv]
// Sequencer for the allocator: walks the table scans, shifts and result hand-off.
// Depends on ssfla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssfla_ctrl
    import ssfla_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire stat_t st,
    output cmd_t       cmd
);

    ctrl_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (s_valid) state_next = S_CHECK;
            S_CHECK: begin
                if (st.is_free)       state_next = S_BS_RD;
                else if (st.bad_size) state_next = S_DONE;
                else                  state_next = S_FS_RD;
            end
            S_FS_RD:     state_next = st.idx_ge_fcnt ? S_ALLOC_NEW : S_FS_CMP;
            S_FS_CMP:    state_next = st.f_ge_sz ? S_RM_RD : S_FS_RD;
            S_RM_RD:     state_next = st.idx_p1_ge_fcnt ? S_FC_RD : S_RM_WR;
            S_RM_WR:     state_next = S_RM_RD;
            S_FC_RD:     state_next = st.idx_ge_ccnt ? S_DONE : S_FC_CMP;
            S_FC_CMP:    state_next = st.b_match ? S_DONE : S_FC_RD;
            S_ALLOC_NEW: state_next = S_DONE;
            S_BS_RD:     state_next = st.idx_ge_ccnt ? S_DONE : S_BS_CMP;
            S_BS_CMP: begin
                if (!st.b_match)                      state_next = S_BS_RD;
                else if (!st.b_in_use || st.fcnt_full) state_next = S_DONE;
                else                                  state_next = S_IP_RD;
            end
            S_IP_RD:     state_next = st.idx_ge_fcnt ? S_SH_RD : S_IP_CMP;
            S_IP_CMP:    state_next = st.f_ge_sz ? S_SH_RD : S_IP_RD;
            S_SH_RD:     state_next = st.idx_le_pos ? S_DONE : S_SH_WR;
            S_SH_WR:     state_next = S_SH_RD;
            S_DONE:      if (st.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        cmd             = '0;
        cmd.idx_op      = IDX_HOLD;
        cmd.free_rd_sel = FRD_IDX;
        cmd.free_wr     = FWR_NONE;
        cmd.blk_wr      = BWR_NONE;
        cmd.fcnt_op     = CNT_HOLD;
        cmd.res_status  = ST_OK;
        cmd.res_addr    = RA_ZERO;
        s_ready         = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.latch  = s_valid;
                cmd.idx_op = IDX_CLR;
            end
            S_CHECK: begin
                if (!st.is_free && st.bad_size) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_BAD_SIZE;
                end
            end
            S_FS_RD: begin
                cmd.free_rd = !st.idx_ge_fcnt;
            end
            S_FS_CMP: begin
                if (st.f_ge_sz) begin
                    cmd.a_from_free = 1'b1;
                end else begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_RM_RD: begin
                if (st.idx_p1_ge_fcnt) begin
                    cmd.fcnt_op = CNT_DEC;
                    cmd.idx_op  = IDX_CLR;
                end else begin
                    cmd.free_rd     = 1'b1;
                    cmd.free_rd_sel = FRD_NEXT;
                end
            end
            S_RM_WR: begin
                cmd.free_wr = FWR_SHIFT;
                cmd.idx_op  = IDX_INC;
            end
            S_FC_RD: begin
                if (st.idx_ge_ccnt) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_addr = RA_FOUND;
                end else begin
                    cmd.blk_rd = 1'b1;
                end
            end
            S_FC_CMP: begin
                if (st.b_match) begin
                    cmd.blk_wr   = BWR_SET_USE;
                    cmd.res_set  = 1'b1;
                    cmd.res_addr = RA_FOUND;
                end else begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_ALLOC_NEW: begin
                cmd.res_set = 1'b1;
                if (st.ccnt_full) begin
                    cmd.res_status = ST_FULL;
                end else if (st.exhausted) begin
                    cmd.res_status = ST_EXHAUSTED;
                end else begin
                    cmd.blk_wr   = BWR_NEW;
                    cmd.res_addr = RA_BUMP;
                end
            end
            S_BS_RD: begin
                if (st.idx_ge_ccnt) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_BAD_PTR;
                end else begin
                    cmd.blk_rd = 1'b1;
                end
            end
            S_BS_CMP: begin
                if (!st.b_match) begin
                    cmd.idx_op = IDX_INC;
                end else if (!st.b_in_use) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_BAD_PTR;
                end else if (st.fcnt_full) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_FULL;
                end else begin
                    cmd.hit_load = 1'b1;
                    cmd.idx_op   = IDX_CLR;
                end
            end
            S_IP_RD: begin
                if (st.idx_ge_fcnt) begin
                    cmd.pos_load = 1'b1;
                    cmd.idx_op   = IDX_FCNT;
                end else begin
                    cmd.free_rd = 1'b1;
                end
            end
            S_IP_CMP: begin
                if (st.f_ge_sz) begin
                    cmd.pos_load = 1'b1;
                    cmd.idx_op   = IDX_FCNT;
                end else begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_SH_RD: begin
                if (st.idx_le_pos) begin
                    cmd.free_wr = FWR_INSERT;
                    cmd.blk_wr  = BWR_CLR_USE;
                    cmd.fcnt_op = CNT_INC;
                    cmd.res_set = 1'b1;
                end else begin
                    cmd.free_rd     = 1'b1;
                    cmd.free_rd_sel = FRD_PREV;
                end
            end
            S_SH_WR: begin
                cmd.free_wr = FWR_SHIFT;
                cmd.idx_op  = IDX_DEC;
            end
            S_DONE: begin
                cmd.out_load = st.out_free;
            end
            default: begin
                cmd.latch = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/ssfla_dp.sv]
// Datapath of the allocator: block and free tables, counters, config registers, result word.
// Depends on ssfla_pkg and ssfla_ram.
`timescale 1ns / 1ps
`default_nettype none

module ssfla_dp
    import ssfla_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire req_t                 s_data,
    output rsp_t                      m_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_BITS-1:0] cfg_data,
    input  wire cmd_t                 cmd,
    output stat_t                     st
);

    logic                 op_reg;
    logic [ADDR_BITS-1:0] a_reg;
    logic [ADDR_BITS-1:0] sz_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     pos_reg;
    logic [CNT_W-1:0]     k_reg;
    logic [CNT_W-1:0]     fcnt_reg;
    logic [CNT_W-1:0]     ccnt_reg;
    logic [ADDR_BITS-1:0] bump_reg;
    logic [ADDR_BITS-1:0] end_reg;
    status_t              res_st_reg;
    logic [ADDR_BITS-1:0] res_addr_reg;
    rsp_t                 out_reg;
    logic                 out_valid_reg;

    logic [CNT_W:0]       idx_p1;
    logic [CNT_W-1:0]     free_raddr_cnt;
    logic [CNT_W-1:0]     free_waddr_cnt;
    logic [CNT_W-1:0]     blk_waddr_cnt;
    free_entry_t          free_rdata;
    free_entry_t          free_wdata;
    blk_entry_t           blk_rdata;
    blk_entry_t           blk_wdata;
    logic                 free_we;
    logic                 blk_we;
    logic                 cfg_base_we;
    logic                 cfg_end_we;

    assign idx_p1      = {1'b0, idx_reg} + 1'b1;
    assign cfg_base_we = cfg_valid && (cfg_reg_t'(cfg_index) == REG_HEAP_BASE);
    assign cfg_end_we  = cfg_valid && (cfg_reg_t'(cfg_index) == REG_HEAP_END);

    // Free table port selection.
    always_comb begin
        unique case (cmd.free_rd_sel)
            FRD_NEXT: free_raddr_cnt = idx_p1[CNT_W-1:0];
            FRD_PREV: free_raddr_cnt = idx_reg - 1'b1;
            default:  free_raddr_cnt = idx_reg;
        endcase
        free_we = (cmd.free_wr != FWR_NONE);
        if (cmd.free_wr == FWR_INSERT) begin
            free_waddr_cnt = pos_reg;
            free_wdata     = '{size: sz_reg, addr: a_reg};
        end else begin
            free_waddr_cnt = idx_reg;
            free_wdata     = free_rdata;
        end
    end

    // Block table port selection.
    always_comb begin
        blk_we = (cmd.blk_wr != BWR_NONE);
        unique case (cmd.blk_wr)
            BWR_NEW: begin
                blk_waddr_cnt = ccnt_reg;
                blk_wdata     = '{addr: bump_reg, size: sz_reg, in_use: 1'b1};
            end
            BWR_SET_USE: begin
                blk_waddr_cnt = idx_reg;
                blk_wdata     = '{addr: blk_rdata.addr, size: blk_rdata.size, in_use: 1'b1};
            end
            default: begin
                blk_waddr_cnt = k_reg;
                blk_wdata     = '{addr: a_reg, size: sz_reg, in_use: 1'b0};
            end
        endcase
    end

    ssfla_ram #(
        .WIDTH($bits(free_entry_t)),
        .DEPTH(FREE_SLOTS)
    ) u_free_ram (
        .aclk  (aclk),
        .we    (free_we),
        .waddr (free_waddr_cnt[FREE_AW-1:0]),
        .wdata (free_wdata),
        .re    (cmd.free_rd),
        .raddr (free_raddr_cnt[FREE_AW-1:0]),
        .rdata (free_rdata)
    );

    ssfla_ram #(
        .WIDTH($bits(blk_entry_t)),
        .DEPTH(BLOCK_SLOTS)
    ) u_blk_ram (
        .aclk  (aclk),
        .we    (blk_we),
        .waddr (blk_waddr_cnt[BLK_AW-1:0]),
        .wdata (blk_wdata),
        .re    (cmd.blk_rd),
        .raddr (idx_reg[BLK_AW-1:0]),
        .rdata (blk_rdata)
    );

    // Request and scan registers.
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg <= s_data.operation;
            a_reg  <= s_data.block_address;
            sz_reg <= s_data.request_size;
        end else if (cmd.a_from_free) begin
            a_reg <= free_rdata.addr;
        end else if (cmd.hit_load) begin
            a_reg  <= blk_rdata.addr;
            sz_reg <= blk_rdata.size;
            k_reg  <= idx_reg;
        end
        if (cmd.pos_load) begin
            pos_reg <= idx_reg;
        end
        if (cmd.res_set) begin
            res_st_reg <= cmd.res_status;
            unique case (cmd.res_addr)
                RA_FOUND: res_addr_reg <= a_reg;
                RA_BUMP:  res_addr_reg <= bump_reg;
                default:  res_addr_reg <= '0;
            endcase
        end
    end

    // Scan index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            unique case (cmd.idx_op)
                IDX_INC:  idx_reg <= idx_p1[CNT_W-1:0];
                IDX_DEC:  idx_reg <= idx_reg - 1'b1;
                IDX_CLR:  idx_reg <= '0;
                IDX_FCNT: idx_reg <= fcnt_reg;
                default:  idx_reg <= idx_reg;
            endcase
        end
    end

    // Table counts, bump pointer and configuration registers. The heap base
    // matters only while nothing is carved, when it moves the bump pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fcnt_reg <= '0;
            ccnt_reg <= '0;
            bump_reg <= BASE_RESET;
            end_reg  <= END_RESET;
        end else begin
            unique case (cmd.fcnt_op)
                CNT_INC: fcnt_reg <= fcnt_reg + 1'b1;
                CNT_DEC: fcnt_reg <= fcnt_reg - 1'b1;
                default: fcnt_reg <= fcnt_reg;
            endcase
            if (cmd.blk_wr == BWR_NEW) begin
                ccnt_reg <= ccnt_reg + 1'b1;
                bump_reg <= bump_reg + sz_reg;
            end else if (cfg_base_we && (ccnt_reg == '0)) begin
                bump_reg <= cfg_data;
            end
            if (cfg_end_we) begin
                end_reg <= cfg_data;
            end
        end
    end

    // Output register, one word waiting for the consumer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.granted_address <= res_addr_reg;
            out_reg.status          <= res_st_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Status to the controller.
    always_comb begin
        st.is_free        = (op_reg == OP_FREE);
        st.bad_size       = (sz_reg == '0) || (sz_reg > SIZE_LIMIT);
        st.idx_ge_fcnt    = (idx_reg >= fcnt_reg);
        st.idx_p1_ge_fcnt = (idx_p1 >= {1'b0, fcnt_reg});
        st.idx_ge_ccnt    = (idx_reg >= ccnt_reg);
        st.idx_le_pos     = (idx_reg <= pos_reg);
        st.f_ge_sz        = (free_rdata.size >= sz_reg);
        st.b_match        = (blk_rdata.addr == a_reg);
        st.b_in_use       = blk_rdata.in_use;
        st.fcnt_full      = (fcnt_reg >= CNT_W'(FREE_SLOTS));
        st.ccnt_full      = (ccnt_reg >= CNT_W'(BLOCK_SLOTS));
        st.exhausted      = (sz_reg > end_reg) || (bump_reg > (end_reg - sz_reg));
        st.out_free       = !out_valid_reg || m_ready;
    end

    // Checks on table bookkeeping.
    a_fcnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= CNT_W'(FREE_SLOTS))
        else $error("free table count beyond capacity");

    a_ccnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ccnt_reg <= CNT_W'(BLOCK_SLOTS))
        else $error("block table count beyond capacity");

    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.free_wr == FWR_INSERT) |-> !st.fcnt_full)
        else $error("insert into a full free table");

    a_bump_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.blk_wr == BWR_NEW) |=> (bump_reg >= $past(bump_reg)))
        else $error("bump pointer wrapped on carve");

endmodule

`default_nettype wire

[hdl/size_sorted_free_list_allocator.sv]
// Size sorted free list allocator: one result word per request word.
// An allocate scans the free table and shifts the rest down, then scans the block table,
// or carves a new block when no free entry fits; a free scans the block table, then scans
// and shifts the free table.
// One request is in work at a time; the next is taken when the sequencer returns to idle.
// Synchronous active low reset sets counts, bump pointer, heap end and control state; tables need no clear.
`timescale 1ns / 1ps
`default_nettype none

module size_sorted_free_list_allocator
    import ssfla_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire req_t                 s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output rsp_t                      m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_BITS-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t st;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    ssfla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    ssfla_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

`default_nettype wire

[dv/size_sorted_free_list_allocator_checker.sv]
// Checker for the size sorted free list allocator: watches the request, result and
// register channels, predicts each result word and compares. Depends on ssfla_pkg.
`timescale 1ns / 1ps

module size_sorted_free_list_allocator_checker
    import ssfla_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  req_t                 s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  rsp_t                 m_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_BITS-1:0] cfg_data,
    output int                   fail_count,
    output int                   pending_results
);

    // Predicted allocator state. The heap base only matters while nothing is carved.
    logic [ADDR_BITS-1:0] end_reg, bump;
    logic [ADDR_BITS-1:0] blk_addr [BLOCK_SLOTS];
    logic [ADDR_BITS-1:0] blk_size [BLOCK_SLOTS];
    logic                 blk_used [BLOCK_SLOTS];
    int                   blk_count;
    logic [ADDR_BITS-1:0] fr_size [FREE_SLOTS];
    logic [ADDR_BITS-1:0] fr_addr [FREE_SLOTS];
    int                   fr_count;
    rsp_t                 expected_words [$];

    assign pending_results = expected_words.size();

    function automatic int find_block(logic [ADDR_BITS-1:0] a);
        for (int i = 0; i < blk_count; i++)
            if (blk_addr[i] == a) return i;
        return -1;
    endfunction

    // Work out the result of one request and update the predicted tables.
    function automatic rsp_t predict_request(req_t rq);
        rsp_t r;
        int   k;
        int   pos;
        r.granted_address = '0;
        r.status = ST_OK;
        if (rq.operation == OP_ALLOC) begin
            if (rq.request_size == 0 || rq.request_size > SIZE_LIMIT) begin
                r.status = ST_BAD_SIZE;
                return r;
            end
            for (int i = 0; i < fr_count; i++) begin
                if (fr_size[i] >= rq.request_size) begin
                    r.granted_address = fr_addr[i];
                    for (int j = i; j + 1 < fr_count; j++) begin
                        fr_size[j] = fr_size[j+1];
                        fr_addr[j] = fr_addr[j+1];
                    end
                    fr_count--;
                    k = find_block(r.granted_address);
                    if (k >= 0) blk_used[k] = 1'b1;
                    return r;
                end
            end
            if (blk_count >= BLOCK_SLOTS) begin
                r.status = ST_FULL;
            end else if (rq.request_size > end_reg || bump > end_reg - rq.request_size) begin
                r.status = ST_EXHAUSTED;
            end else begin
                blk_addr[blk_count] = bump;
                blk_size[blk_count] = rq.request_size;
                blk_used[blk_count] = 1'b1;
                blk_count++;
                r.granted_address = bump;
                bump = bump + rq.request_size;
            end
        end else begin
            k = find_block(rq.block_address);
            if (k < 0 || !blk_used[k]) begin
                r.status = ST_BAD_PTR;
            end else if (fr_count >= FREE_SLOTS) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < fr_count && fr_size[pos] < blk_size[k]) pos++;
                for (int j = fr_count; j > pos; j--) begin
                    fr_size[j] = fr_size[j-1];
                    fr_addr[j] = fr_addr[j-1];
                end
                fr_size[pos] = blk_size[k];
                fr_addr[pos] = blk_addr[k];
                fr_count++;
                blk_used[k] = 1'b0;
            end
        end
        return r;
    endfunction

    // Sample all three channels at the clock edge.
    always @(posedge aclk) begin
        rsp_t e;
        if (!aresetn) begin
            end_reg    = END_RESET;
            bump       = BASE_RESET;
            blk_count  = 0;
            fr_count   = 0;
            fail_count <= 0;
            expected_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_HEAP_BASE) begin
                    if (blk_count == 0) bump = cfg_data;
                end else begin
                    end_reg = cfg_data;
                end
            end
            if (s_valid && s_ready) expected_words.push_back(predict_request(s_data));
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result word addr=%h st=%0d",
                                 m_data.granted_address, m_data.status);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_words.pop_front();
                    if (e !== m_data) begin
                        if (fail_count < 10)
                            $display("ERROR: expected addr=%h st=%0d, got addr=%h st=%0d",
                                     e.granted_address, e.status,
                                     m_data.granted_address, m_data.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[dv/size_sorted_free_list_allocator_tb.sv]
// Testbench top for the size sorted free list allocator: drives requests, register
// writes and result back-pressure; the checker module does prediction. Depends on ssfla_pkg.
`timescale 1ns / 1ps

module size_sorted_free_list_allocator_tb;
    import ssfla_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    req_t                 s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    rsp_t                 m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_BITS-1:0] cfg_data = '0;
    int                   fail_count;
    int                   pending_results;
    int                   cycle_count = 0;
    bit                   long_hold = 1'b0;
    logic [ADDR_BITS-1:0] granted_log [$];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    size_sorted_free_list_allocator u_dut (.*);

    size_sorted_free_list_allocator_checker u_chk (.*);

    // Keep a record of granted addresses so frees can target real blocks.
    always @(posedge aclk)
        if (m_valid && m_ready && m_data.granted_address != 0)
            granted_log.push_back(m_data.granted_address);

    // Overall watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result back-pressure: random waits, plus one long hold-off.
    // Ready drops only when a wait follows, so it is driven once per edge.
    initial begin
        int w;
        @(posedge aclk iff aresetn);
        forever begin
            w = long_hold ? 0 : ((cycle_count % 3000 < 1000) ? 0 : $urandom_range(0, 4));
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (2000) @(posedge aclk);
                long_hold = 1'b0;
            end else if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    // Valid drops only when a wait follows; a burst ends with stop_input.
    task automatic send_word(logic op, logic [ADDR_BITS-1:0] sz, logic [ADDR_BITS-1:0] ad,
                             bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 4) : 0;
        if (w > 0) begin
            s_valid <= 1'b0;
            repeat (w) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{operation: op, request_size: sz, block_address: ad};
        @(posedge aclk iff s_ready);
    endtask

    task automatic stop_input();
        s_valid <= 1'b0;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [ADDR_BITS-1:0] val);
        stop_input();
        @(posedge aclk);
        wait (pending_results == 0);
        repeat (500) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ADDR_BITS-1:0] pick_address();
        if (granted_log.size() > 0 && $urandom_range(0, 9) != 0)
            return granted_log[$urandom_range(0, granted_log.size() - 1)];
        return ADDR_BITS'($urandom);
    endfunction

    // Random phase: mostly small allocations and frees of granted blocks.
    task automatic random_phase(int n);
        logic [ADDR_BITS-1:0] sz;
        bit                   gaps;
        for (int i = 0; i < n; i++) begin
            gaps = (i % 100) >= 30;
            case ($urandom_range(0, 9))
                0: sz = ADDR_BITS'($urandom);
                1: sz = ADDR_BITS'($urandom_range(0, 3));
                default: sz = ADDR_BITS'($urandom_range(1, 4096));
            endcase
            if ($urandom_range(0, 1))
                send_word(OP_ALLOC, sz, ADDR_BITS'($urandom), gaps);
            else
                send_word(OP_FREE, ADDR_BITS'($urandom), pick_address(), gaps);
        end
    endtask

    initial begin
        logic [ADDR_BITS-1:0] a;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: move the base while nothing is carved, then the field extremes.
        write_reg(REG_HEAP_BASE, 28'h0000100);
        send_word(OP_ALLOC, '0, '1, 1'b0);
        send_word(OP_ALLOC, SIZE_LIMIT + 28'd1, '0, 1'b0);
        send_word(OP_ALLOC, '1, '0, 1'b0);
        send_word(OP_ALLOC, SIZE_LIMIT, '1, 1'b0);
        send_word(OP_ALLOC, 28'd100, '0, 1'b0);
        send_word(OP_ALLOC, 28'd50, '0, 1'b0);
        send_word(OP_FREE, '1, 28'h0000100, 1'b0);
        send_word(OP_FREE, '0, 28'h0000100, 1'b0);
        send_word(OP_FREE, '0, '1, 1'b0);
        send_word(OP_FREE, '0, 28'h0000101, 1'b0);
        send_word(OP_ALLOC, 28'd60, '0, 1'b0);
        send_word(OP_ALLOC, 28'd60, '0, 1'b0);
        // A base write after carving has no effect.
        write_reg(REG_HEAP_BASE, 28'h0ABCDEF);
        write_reg(REG_HEAP_END, 28'h0000400);
        send_word(OP_ALLOC, 28'd900, '0, 1'b0);
        send_word(OP_ALLOC, 28'd1000, '0, 1'b0);

        // Fill the block table, then overflow it.
        write_reg(REG_HEAP_END, '1);
        for (int i = 0; i < 64; i++) send_word(OP_ALLOC, 28'd16, '0, 1'b0);
        stop_input();
        // Free a run of addresses from 0x100; only the first matches a carved block.
        wait (pending_results == 0);
        for (int i = 0; i < 70; i++) begin
            a = 28'h0000100 + 28'd16 * ADDR_BITS'(i);
            send_word(OP_FREE, '0, a, 1'b1);
        end

        // Random traffic, with one long receiver hold-off mid-way.
        random_phase(400);
        stop_input();
        @(posedge aclk);
        wait (pending_results == 0);
        long_hold = 1'b1;
        random_phase(400);

        // Shrink the heap end to zero, then to a tight value.
        write_reg(REG_HEAP_END, 28'd0);
        random_phase(100);
        write_reg(REG_HEAP_END, 28'h0080000);
        random_phase(300);
        stop_input();

        @(posedge aclk);
        wait (pending_results == 0);
        repeat (600) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/ssfla_pkg.sv
hdl/ssfla_ram.sv
hdl/ssfla_ctrl.sv
hdl/ssfla_dp.sv
hdl/size_sorted_free_list_allocator.sv
dv/size_sorted_free_list_allocator_checker.sv
dv/size_sorted_free_list_allocator_tb.sv
